/* rtl/core/lcfh_pkg.sv */
// Package for the log-count feature hasher: payload and control structs,
// hash constants and register index codes.
// No dependencies; every other file of the block imports it.
package lcfh_pkg;

   localparam logic [31:0] MUL_K = 32'd2654435761;
   localparam logic [31:0] ADD_K = 32'd2654435769;

   // Left and right shifts of the running seed in each combine round.
   localparam int SEED_SHL = 6;
   localparam int SEED_SHR = 2;

   // Largest number of levels one beat may expand into.
   localparam logic [4:0] LEVEL_CAP = 5'd16;

   localparam int DEFAULT_COUNT_BITS = 16;

   localparam logic [4:0] MAX_LEVELS_RESET = 5'd8;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LOG_LEVELS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUERY_MODE     = 1'b1;

   typedef struct packed {
      logic [31:0] feature_hash;
      logic [15:0] occurrence_count;
      logic [1:0]  source_id;
   } lcfh_req_type;

   typedef struct packed {
      logic [31:0] bit_hash;
      logic [3:0]  level;
      logic        last;
   } lcfh_rsp_type;

   typedef struct packed {
      logic [4:0] max_log_levels;
      logic       query_mode;
   } lcfh_cfg_type;

   // One hash job handed from the level sequencer to the hash pipeline.
   typedef struct packed {
      logic        valid;
      logic [31:0] feature_hash;
      logic [1:0]  source_id;
      logic [3:0]  level;
      logic        last;
   } lcfh_issue_type;

endpackage

/* rtl/core/lcfh_expander.sv */
// Level sequencer: takes one request beat and steps through its count levels,
// one per cycle while advance is high, issuing hash jobs. Depends on lcfh_pkg.
module lcfh_expander
   import lcfh_pkg::*;
#(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  logic           clock,
   input  logic           reset,
   input  lcfh_cfg_type   cfg,
   input  logic           req_valid,
   output logic           req_stall,
   input  lcfh_req_type   req_data,
   input  logic           advance,
   output lcfh_issue_type issue
);

   localparam int CntW = (COUNT_BITS < 16) ? COUNT_BITS : 16;

   logic            busy_ff, busy_in;
   logic            zero_ff, zero_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [3:0]      lv_ff, lv_in;
   logic [31:0]     feat_ff, feat_in;
   logic [1:0]      src_ff, src_in;

   logic [4:0]      cap;
   logic [4:0]      lv_next;
   logic            done;
   logic            take;
   logic            cnt_nz;

   assign cap     = (cfg.max_log_levels > LEVEL_CAP) ? LEVEL_CAP : cfg.max_log_levels;
   assign lv_next = {1'b0, lv_ff} + 5'd1;
   // The current level is the final one when the halved count runs out or the
   // cap is reached. A zero query is a single beat at level zero.
   assign done    = zero_ff || ((cnt_ff >> 1) == '0) || (lv_next >= cap);

   assign req_stall = busy_ff && !(done && advance);
   assign take      = req_valid && !req_stall;
   assign cnt_nz    = (req_data.occurrence_count[CntW-1:0] != '0);

   assign issue.valid        = busy_ff && (!cfg.query_mode || done);
   assign issue.feature_hash = feat_ff;
   assign issue.source_id    = src_ff;
   assign issue.level        = zero_ff ? 4'd0 : lv_ff;
   assign issue.last         = done;

   always_comb begin
      busy_in = busy_ff;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      lv_in   = lv_ff;
      feat_in = feat_ff;
      src_in  = src_ff;
      if (take) begin
         busy_in = cfg.query_mode || (cnt_nz && (cap != 5'd0));
         zero_in = !cnt_nz || (cap == 5'd0);
         cnt_in  = req_data.occurrence_count[CntW-1:0];
         lv_in   = 4'd0;
         feat_in = req_data.feature_hash;
         src_in  = req_data.source_id;
      end else if (busy_ff && advance) begin
         if (done) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff >> 1;
            lv_in  = lv_next[3:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      lv_ff   <= lv_in;
      feat_ff <= feat_in;
      src_ff  <= src_in;
   end

endmodule

/* rtl/core/lcfh_hash_pipe.sv */
// Three-stage hash-combine pipeline: products, level round, feature round
// into the output register. Depends on lcfh_pkg.
module lcfh_hash_pipe
   import lcfh_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  lcfh_issue_type issue,
   output logic           advance,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output lcfh_rsp_type   rsp_data
);

   logic        v1_ff, v2_ff, v3_ff;
   logic [31:0] s1_ff, s1_in;
   logic [31:0] lvk_ff, lvk_in;
   logic [31:0] featk1_ff, featk1_in;
   logic [3:0]  lv1_ff;
   logic        last1_ff;
   logic [31:0] s2_ff, s2_in;
   logic [31:0] featk2_ff;
   logic [3:0]  lv2_ff;
   logic        last2_ff;
   logic [31:0] s3_in;
   lcfh_rsp_type out_ff;

   // The whole pipeline holds while a finished beat waits at the output.
   assign advance = !v3_ff || !rsp_stall;

   // The first round starts from a zero seed, so it is just the scaled source.
   assign s1_in     = {30'd0, issue.source_id} * MUL_K + ADD_K;
   assign lvk_in    = {28'd0, issue.level} * MUL_K;
   assign featk1_in = issue.feature_hash * MUL_K;

   assign s2_in = s1_ff ^ (lvk_ff + ADD_K + (s1_ff << SEED_SHL) + (s1_ff >> SEED_SHR));
   assign s3_in = s2_ff ^ (featk2_ff + ADD_K + (s2_ff << SEED_SHL) + (s2_ff >> SEED_SHR));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= issue.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff           <= s1_in;
         lvk_ff          <= lvk_in;
         featk1_ff       <= featk1_in;
         lv1_ff          <= issue.level;
         last1_ff        <= issue.last;
         s2_ff           <= s2_in;
         featk2_ff       <= featk1_ff;
         lv2_ff          <= lv1_ff;
         last2_ff        <= last1_ff;
         out_ff.bit_hash <= s3_in;
         out_ff.level    <= lv2_ff;
         out_ff.last     <= last2_ff;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = out_ff;

endmodule

/* rtl/core/log_count_feature_hasher.sv */
// Log-count feature hasher top level: configuration registers, level
// sequencer and hash pipeline. Depends on lcfh_pkg, lcfh_expander, lcfh_hash_pipe.
//
// A request beat carries a feature hash, an occurrence count and a source id.
// In index mode the block returns one response beat per count level, from
// level 0 up while the halved count stays nonzero and below max_log_levels;
// a zero count returns nothing. In query mode it returns one beat at the
// highest level reached (level 0 for a zero count). The final beat of each
// request has last set.
// The sequencer walks one level per cycle while the pipeline advances, so a
// request holds the input until its walk of at most 16 levels is done, in
// both modes. In index mode each level goes through the three-stage hash
// pipeline as its own response, and later levels follow one per cycle while
// the output is not stalled; in query mode the single response leaves the
// pipeline once the walk has reached the top level. A stall on rsp_stall
// freezes the pipeline and the sequencer together; the request side then sees
// req_stall once the current request is held. Reset (synchronous) empties the
// pipeline, drops any request in progress and sets max_log_levels to 8 and
// query_mode to 0. Registers are written through csr_we/csr_index/csr_wdata
// by the user, only while the block is idle; the block itself does not enforce this.
module log_count_feature_hasher
   import lcfh_pkg::*;
#(
   parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lcfh_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lcfh_rsp_type           rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   lcfh_cfg_type   cfg_ff, cfg_in;
   lcfh_issue_type issue;
   logic           advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_LOG_LEVELS: cfg_in.max_log_levels = csr_wdata;
            CSR_QUERY_MODE:     cfg_in.query_mode     = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_log_levels <= MAX_LEVELS_RESET;
         cfg_ff.query_mode     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcfh_expander #(
      .COUNT_BITS(COUNT_BITS)
   ) u_expander (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .issue     (issue)
   );

   lcfh_hash_pipe u_hash_pipe (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A held request must not drift while the pipeline is frozen.
   a_issue_hold: assert property (@(posedge clock) disable iff (reset)
      (req_stall && !advance) |=> ($stable(issue.level) && $stable(issue.feature_hash)))
      else $error("issued job changed while the pipeline was stalled");

   // Level fifteen is always the final level of a request.
   a_top_level_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.level == 4'd15)) |-> rsp_data.last)
      else $error("level fifteen response without last");

   // Query mode issues only the final job of each request.
   a_query_single: assert property (@(posedge clock) disable iff (reset)
      (issue.valid && !issue.last) |-> !cfg_ff.query_mode)
      else $error("non-final job issued in query mode");

endmodule

/* sim/tb_log_count_feature_hasher.sv */
// Self-checking testbench for log_count_feature_hasher: a table of directed
// beats across several register settings, then random beats under random stalls.
// Depends on lcfh_pkg and the log_count_feature_hasher RTL.
module tb_log_count_feature_hasher;
   import lcfh_pkg::*;

   localparam logic [31:0] GOLDEN_MUL = 32'h9E3779B1;
   localparam logic [31:0] GOLDEN_ADD = 32'h9E3779B9;
   localparam int SETTLE_CYCLES  = 24;
   localparam int TIMEOUT_CYCLES = 1000000;
   localparam int PHASE_ITEMS    = 60;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_style_type;

   // One directed beat with the register setting it runs under. Where typed is
   // set, the expected levels are written here; otherwise the predictor decides.
   typedef struct packed {
      logic [4:0]  cap;
      logic        qm;
      logic [31:0] feat;
      logic [15:0] cnt;
      logic [1:0]  src;
      logic        typed;
      logic [4:0]  beats;
      logic [3:0]  peak;
   } probe_row_type;

   localparam int NUM_PROBES = 19;

   probe_row_type probes [0:NUM_PROBES-1] = '{
      '{5'd8,  1'b0, 32'h00000000, 16'h0000, 2'd0, 1'b1, 5'd0,  4'd0},
      '{5'd8,  1'b0, 32'hFFFFFFFF, 16'hFFFF, 2'd3, 1'b1, 5'd8,  4'd0},
      '{5'd8,  1'b0, 32'h12345678, 16'h0001, 2'd1, 1'b1, 5'd1,  4'd0},
      '{5'd8,  1'b0, 32'hA5A5A5A5, 16'h0005, 2'd2, 1'b0, 5'd0,  4'd0},
      '{5'd8,  1'b0, 32'h5A5A5A5A, 16'h00FF, 2'd0, 1'b1, 5'd8,  4'd0},
      '{5'd16, 1'b0, 32'hFFFFFFFF, 16'hFFFF, 2'd3, 1'b1, 5'd16, 4'd0},
      '{5'd16, 1'b0, 32'h00000001, 16'h8000, 2'd1, 1'b1, 5'd16, 4'd0},
      '{5'd31, 1'b0, 32'hDEADBEEF, 16'hFFFF, 2'd2, 1'b1, 5'd16, 4'd0},
      '{5'd17, 1'b0, 32'h0F0F0F0F, 16'h7FFF, 2'd1, 1'b0, 5'd0,  4'd0},
      '{5'd0,  1'b0, 32'h13579BDF, 16'hFFFF, 2'd3, 1'b1, 5'd0,  4'd0},
      '{5'd1,  1'b0, 32'h2468ACE0, 16'hFFFF, 2'd2, 1'b1, 5'd1,  4'd0},
      '{5'd8,  1'b1, 32'hCAFEF00D, 16'h0000, 2'd1, 1'b1, 5'd1,  4'd0},
      '{5'd8,  1'b1, 32'hFFFFFFFF, 16'hFFFF, 2'd3, 1'b1, 5'd1,  4'd7},
      '{5'd8,  1'b1, 32'h00000000, 16'h0006, 2'd0, 1'b0, 5'd0,  4'd0},
      '{5'd0,  1'b1, 32'h11111111, 16'hFFFF, 2'd2, 1'b1, 5'd1,  4'd0},
      '{5'd16, 1'b1, 32'h80000000, 16'hFFFF, 2'd1, 1'b1, 5'd1,  4'd15},
      '{5'd31, 1'b1, 32'h7FFFFFFF, 16'h8000, 2'd3, 1'b1, 5'd1,  4'd15},
      '{5'd31, 1'b1, 32'h00000000, 16'h0001, 2'd0, 1'b1, 5'd1,  4'd0},
      '{5'd2,  1'b0, 32'h87654321, 16'h0003, 2'd3, 1'b0, 5'd0,  4'd0}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   lcfh_req_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   lcfh_rsp_type           rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Register copies as the block should hold them.
   logic [4:0] cur_levels;
   logic       cur_query;

   lcfh_rsp_type awaited_hashes[$];
   int         fault_count;
   bit         valid_up;
   int         burst_left;

   log_count_feature_hasher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("tb_log_count_feature_hasher: errors");
      $finish;
   end

   function automatic logic [31:0] mix_round(logic [31:0] x, logic [31:0] seed);
      logic [31:0] t;
      t = x * GOLDEN_MUL + GOLDEN_ADD + (seed << 6) + (seed >> 2);
      return seed ^ t;
   endfunction

   function automatic logic [31:0] fingerprint_hash(logic [1:0] src, logic [3:0] lv,
                                                    logic [31:0] feat);
      logic [31:0] s;
      s = 32'd0;
      s = mix_round({30'd0, src}, s);
      s = mix_round({28'd0, lv}, s);
      s = mix_round(feat, s);
      return s;
   endfunction

   function automatic void post_hash(lcfh_req_type r, logic [3:0] lv, logic fin);
      lcfh_rsp_type beat;
      beat.bit_hash = fingerprint_hash(r.source_id, lv, r.feature_hash);
      beat.level    = lv;
      beat.last     = fin;
      awaited_hashes.push_back(beat);
   endfunction

   // Walks the halved count up through the levels under the current setting.
   function automatic void expand_feature(lcfh_req_type r);
      int unsigned cnt;
      int          limit;
      int          lv;
      logic [3:0]  peak;
      cnt   = r.occurrence_count;
      limit = (cur_levels > 5'd16) ? 16 : int'(cur_levels);
      peak  = 4'd0;
      lv    = 0;
      while (cnt != 0 && lv < limit) begin
         if (cur_query)
            peak = lv[3:0];
         else
            post_hash(r, lv[3:0], ((cnt >> 1) == 0) || (lv + 1 == limit));
         lv++;
         cnt = cnt >> 1;
      end
      if (cur_query)
         post_hash(r, peak, 1'b1);
   endfunction

   function automatic void typed_levels(lcfh_req_type r, logic [4:0] beats,
                                        logic [3:0] peak);
      int i;
      if (cur_query) begin
         post_hash(r, peak, 1'b1);
      end else begin
         for (i = 0; i < beats; i++)
            post_hash(r, i[3:0], i == beats - 1);
      end
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("%s", msg);
   endtask

   always @(posedge clock) begin
      lcfh_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_hashes.size() == 0) begin
            note_fault($sformatf("unexpected beat: hash %h level %0d last %0d",
                                 rsp_data.bit_hash, rsp_data.level, rsp_data.last));
         end else begin
            want = awaited_hashes.pop_front();
            if (rsp_data.bit_hash !== want.bit_hash || rsp_data.level !== want.level ||
                rsp_data.last !== want.last)
               note_fault($sformatf("beat mismatch: want %h/%0d/%0d got %h/%0d/%0d",
                                    want.bit_hash, want.level, want.last,
                                    rsp_data.bit_hash, rsp_data.level, rsp_data.last));
         end
      end
   end

   // The receiver switches at random between stall styles.
   initial begin
      stall_style_type style;
      int              span;
      int              run_left;
      logic            hold;
      run_left = 0;
      hold = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         style = stall_style_type'($urandom_range(0, 3));
         span  = $urandom_range(40, 250);
         repeat (span) begin
            @(posedge clock);
            case (style)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: begin
                  if (run_left == 0) begin
                     run_left = $urandom_range(1, 20);
                     hold = ~hold;
                  end
                  run_left--;
                  rsp_stall <= hold;
               end
            endcase
         end
      end
   end

   task automatic drop_valid();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 0;
      end
   endtask

   task automatic settle_idle();
      drop_valid();
      while (awaited_hashes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leaves csr_we high; the caller lowers it after its last write.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_MAX_LOG_LEVELS)
         cur_levels = data;
      else
         cur_query = data[0];
      @(posedge clock);
   endtask

   task automatic pace_sender(input bit idle_ok);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = idle_ok ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            drop_valid();
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic push_req(input lcfh_req_type d, input bit typed,
                           input logic [4:0] beats, input logic [3:0] peak);
      req_data  <= d;
      req_valid <= 1'b1;
      valid_up = 1;
      do @(posedge clock); while (req_stall);
      if (typed)
         typed_levels(d, beats, peak);
      else
         expand_feature(d);
   endtask

   function automatic lcfh_req_type random_req();
      lcfh_req_type r;
      int sel;
      sel = $urandom_range(0, 19);
      r.feature_hash = $urandom;
      r.source_id    = 2'($urandom_range(0, 3));
      if (sel == 0)
         r.occurrence_count = 16'd0;
      else if (sel <= 11)
         r.occurrence_count = 16'($urandom_range(1, 15));
      else if (sel <= 14)
         r.occurrence_count = 16'd1 << $urandom_range(0, 15);
      else if (sel <= 16)
         r.occurrence_count = 16'hFFFF >> $urandom_range(0, 15);
      else
         r.occurrence_count = 16'($urandom);
      return r;
   endfunction

   initial begin
      int           phase_caps [0:6];
      bit           phase_qms  [0:6];
      int           i;
      int           p;
      int           k;
      int           drain_at;
      lcfh_req_type d;
      logic [4:0]   qm_word;

      phase_caps = '{16, 3, 31, 0, 12, 1, 0};
      phase_qms  = '{0, 1, 0, 1, 1, 0, 0};
      fault_count = 0;
      valid_up = 0;
      burst_left = 0;
      cur_levels = MAX_LEVELS_RESET;
      cur_query = 1'b0;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < NUM_PROBES; i++) begin
         if (probes[i].cap != cur_levels || probes[i].qm != cur_query) begin
            settle_idle();
            if (probes[i].cap != cur_levels)
               write_csr(CSR_MAX_LOG_LEVELS, probes[i].cap);
            if (probes[i].qm != cur_query)
               write_csr(CSR_QUERY_MODE, {4'd0, probes[i].qm});
            csr_we <= 1'b0;
         end
         d.feature_hash     = probes[i].feat;
         d.occurrence_count = probes[i].cnt;
         d.source_id        = probes[i].src;
         pace_sender(1);
         push_req(d, probes[i].typed, probes[i].beats, probes[i].peak);
      end

      for (p = 0; p < 7; p++) begin
         settle_idle();
         if (p == 6) begin
            phase_caps[p] = $urandom_range(0, 31);
            phase_qms[p]  = (phase_caps[p] == 0) ? 1'b1 : 1'($urandom_range(0, 1));
         end
         // Upper bits of the mode word are junk; only bit zero should count.
         qm_word = 5'($urandom_range(0, 31));
         qm_word[0] = phase_qms[p];
         write_csr(CSR_MAX_LOG_LEVELS, 5'(phase_caps[p]));
         write_csr(CSR_QUERY_MODE, qm_word);
         csr_we <= 1'b0;
         drain_at = $urandom_range(10, 50);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k == drain_at)
               settle_idle();
            pace_sender(p != 0);
            push_req(random_req(), 1'b0, 5'd0, 4'd0);
         end
      end

      settle_idle();
      if (fault_count == 0)
         $display("tb_log_count_feature_hasher: clean");
      else
         $display("tb_log_count_feature_hasher: errors");
      $finish;
   end

endmodule
